[sv/afi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afi_pkg: shared definitions of the array mode index finder
// Default sizes, port widths, the search sequencer state and the control and
// status bundles passed between the top level and the sequencer.
// ----------------------------------------------------------------------------
package afi_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int ELEM_WIDTH_DEF = 64;
    localparam int IN_WIDTH       = 64;
    localparam int IDX_WIDTH      = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REF,
        S_LOADREF,
        S_SCAN,
        S_DONE
    } t_state;

    // Top level to sequencer.
    typedef struct packed {
        logic start;
        logic take;
    } t_seq_ctrl;

    // Sequencer to top level.
    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

endpackage

[sv/afi_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afi_store: element memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module afi_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/afi_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afi_seq: all-pairs search sequencer
// Walks each stored element as reference, sweeps the store through one
// equality comparator and hit counter, and keeps the first best index.
// ----------------------------------------------------------------------------
module afi_seq
    import afi_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_seq_ctrl                  i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  logic [ELEM_WIDTH-1:0]      i_rd_data,
    output logic [$clog2(DEPTH)-1:0]   o_rd_addr,
    output logic [$clog2(DEPTH)-1:0]   o_best_index,
    output t_seq_stat                  o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_i;
    logic [CW-1:0]         r_j;
    logic [ELEM_WIDTH-1:0] r_ref;
    logic [CW-1:0]         r_hits;
    logic [CW-1:0]         r_best_count;
    logic [AW-1:0]         r_best_index;

    logic [CW-1:0] n_hits;
    logic          sweep_end;
    logic          last_ref;

    // The data on the read port belongs to address r_j - 1 while scanning.
    assign n_hits    = r_hits + CW'(i_rd_data == r_ref);
    assign sweep_end = (r_j == i_count);
    assign last_ref  = ((CW'(r_i) + CW'(1)) == i_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    n_state = i_ctrl.start ? S_REF : S_IDLE;
            S_REF:     n_state = S_LOADREF;
            S_LOADREF: n_state = S_SCAN;
            S_SCAN: begin
                if (sweep_end) begin
                    n_state = last_ref ? S_DONE : S_REF;
                end
            end
            S_DONE:    n_state = i_ctrl.take ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_rd_addr   = '0;
        o_stat.idle = 1'b0;
        o_stat.done = 1'b0;
        unique case (r_state)
            S_IDLE:    o_stat.idle = 1'b1;
            S_REF:     o_rd_addr = r_i;
            S_LOADREF: o_rd_addr = '0;
            S_SCAN:    o_rd_addr = r_j[AW-1:0];
            S_DONE:    o_stat.done = 1'b1;
            default:   o_rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_i          <= '0;
            r_j          <= '0;
            r_hits       <= '0;
            r_best_count <= '0;
            r_best_index <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_ctrl.start) begin
                        r_i          <= '0;
                        r_best_count <= '0;
                        r_best_index <= '0;
                    end
                end
                S_LOADREF: begin
                    r_j    <= CW'(1);
                    r_hits <= '0;
                end
                S_SCAN: begin
                    r_hits <= n_hits;
                    if (!sweep_end) begin
                        r_j <= r_j + CW'(1);
                    end else begin
                        // Strictly greater keeps the lowest index on a tie.
                        if (n_hits > r_best_count) begin
                            r_best_count <= n_hits;
                            r_best_index <= r_i;
                        end
                        r_i <= r_i + AW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOADREF) begin
            r_ref <= i_rd_data;
        end
    end

    assign o_best_index = r_best_index;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j <= i_count))
        else $error("scan pointer ran past the element count");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((CW'(r_best_index) < i_count) && (r_best_count <= i_count)
                                 && (r_best_count != '0)))
        else $error("search result outside the loaded array");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && i_ctrl.start) |=> (r_state == S_REF))
        else $error("search did not start");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !i_ctrl.take) |=> ((r_state == S_DONE) && $stable(r_best_index)))
        else $error("result changed before it was taken");

endmodule

[sv/array_mode_index_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_mode_index_finder: index of the most frequent element of an array
// Loads an array one element per beat and reports the lowest index of an
// element with the greatest number of bit-equal elements.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one element per beat.
// The beat with i_is_last set closes the array and starts the search. Only
// the low ELEM_WIDTH bits of each element are stored and compared. Elements
// that arrive once DEPTH are stored are dropped, and the result then reports
// o_overflow.
// While loading, o_in_ready stays high. After the closing beat the search
// compares each stored element against every stored element, itself included,
// through a single comparator and a single memory read port; o_in_ready is
// low while it runs. The result beat (o_out_valid / i_out_ready) sits in an
// output register, so the next array may be loaded while it waits; a finished
// search holds until that register is free. o_mode_index carries the low six
// bits of the index. Reset empties the array and drops any pending result; the
// element memory itself is not cleared, since only entries written for the
// current array are read.
// ----------------------------------------------------------------------------
module array_mode_index_finder
    import afi_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [IN_WIDTH-1:0]  i_element_value,
    input  logic                 i_is_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [IDX_WIDTH-1:0] o_mode_index,
    output logic                 o_overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_seq_ctrl             seq_ctrl;
    t_seq_stat             seq_stat;
    logic [AW-1:0]         rd_addr;
    logic [ELEM_WIDTH-1:0] rd_data;
    logic [AW-1:0]         best_index;

    logic [CW-1:0]        r_fill;
    logic                 r_dropped;
    logic                 r_out_valid;
    logic [IDX_WIDTH-1:0] r_mode_index;
    logic                 r_overflow;

    logic in_beat;
    logic store_full;
    logic wr_en;

    // The input side is open only while the sequencer is idle.
    assign o_in_ready = seq_stat.idle;
    assign in_beat    = i_in_valid && o_in_ready;
    assign store_full = (r_fill >= CW'(DEPTH));
    assign wr_en      = in_beat && !store_full;

    // A finished search moves into the output register once it is free.
    assign seq_ctrl.start = in_beat && i_is_last;
    assign seq_ctrl.take  = seq_stat.done && (!r_out_valid || i_out_ready);

    afi_store #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_element_value[ELEM_WIDTH-1:0]),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    afi_seq #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (seq_ctrl),
        .i_count      (r_fill),
        .i_rd_data    (rd_data),
        .o_rd_addr    (rd_addr),
        .o_best_index (best_index),
        .o_stat       (seq_stat)
    );

    // Fill count and drop flag stay fixed during the search; the sequencer
    // uses the fill count as the array length. Both clear when the result
    // leaves the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else if (seq_ctrl.take) begin
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else if (in_beat) begin
            if (store_full) begin
                r_dropped <= 1'b1;
            end else begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_ctrl.take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ctrl.take) begin
            r_mode_index <= IDX_WIDTH'(best_index);
            r_overflow   <= r_dropped;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode_index = r_mode_index;
    assign o_overflow   = r_overflow;

endmodule
